// File: design/skf_pkg.sv
package skf_pkg;

    localparam int SAMPLE_BITS_DEFAULT   = 16;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int EST_BITS  = 32;
    localparam int COV_BITS  = 32;
    localparam int NOISE_BITS = 32;
    localparam int GAIN_BITS = 16;
    localparam int ERR_BITS  = EST_BITS + 1;
    // Gain operand is widened by one sign bit before it meets the signed error.
    localparam int PROD_BITS = GAIN_BITS + 2 + ERR_BITS;
    localparam int DELTA_BITS = PROD_BITS - GAIN_BITS;
    localparam int DIV_CNT_BITS = $clog2(GAIN_BITS);

    localparam logic [GAIN_BITS:0] GAIN_ONE = (GAIN_BITS + 1)'(1) << GAIN_BITS;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEASUREMENT_NOISE = 2'd1;

    localparam logic [NOISE_BITS-1:0] PROCESS_NOISE_RESET     = 32'd655;
    localparam logic [NOISE_BITS-1:0] MEASUREMENT_NOISE_RESET = 32'd65536;

    typedef struct packed {
        logic                start;
        logic [COV_BITS-1:0] num;
        logic [COV_BITS:0]   den;
    } div_request_t;

    typedef struct packed {
        logic               done;
        logic [GAIN_BITS:0] quotient;
    } div_status_t;

    typedef struct packed {
        logic                       enable;
        logic [GAIN_BITS:0]         a;
        logic signed [ERR_BITS-1:0] b;
    } mul_request_t;

endpackage

// File: design/scalar_kalman_filter.sv
// Scalar Kalman filter for a stream of sensor samples.
// Input channel: in_valid/in_ready with a signed integer sample per beat.
// Output channel: out_valid/out_ready with the new Q16.16 estimate and the
// unsigned Q1.16 gain used for that sample, one output beat per input beat.
// Configuration channel: cfg_valid/cfg_ready (always ready) with cfg_index
// 0 for process noise q and 1 for measurement noise r, both unsigned Q16.16.
// Other indexes are ignored. Write configuration only while the filter is idle.
// Each accepted beat steps through predict, divider start, divide, estimate
// multiply, covariance multiply, covariance write and finish; a trivial gain
// (zero divisor or zero measurement noise) skips the divider's bit loop.
// The gain comes from a restoring divider that retires one quotient bit per
// cycle; one registered multiplier is then used twice, first for the estimate
// update and then for the covariance update.
// One sample is processed at a time; the next beat waits for the idle state.
// The finished result sits in an output register; if the receiver stalls,
// the next sample is accepted but its result waits until the previous beat
// has been taken.
// Reset clears the estimate and covariance and loads q = 655 and r = 65536.
module scalar_kalman_filter #(
    parameter int SAMPLE_BITS   = skf_pkg::SAMPLE_BITS_DEFAULT,
    parameter int FRACTION_BITS = skf_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [skf_pkg::EST_BITS-1:0]   estimate,
    output logic [skf_pkg::GAIN_BITS:0]           gain,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [skf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [skf_pkg::NOISE_BITS-1:0]        cfg_data
);

    localparam int EXTW = (SAMPLE_BITS + FRACTION_BITS > skf_pkg::EST_BITS) ?
                          SAMPLE_BITS + FRACTION_BITS : skf_pkg::EST_BITS + 1;
    localparam logic signed [EXTW-1:0] MEAS_MAX = EXTW'(64'sh7fffffff);
    localparam logic signed [EXTW-1:0] MEAS_MIN = EXTW'(-64'sh80000000);
    localparam logic signed [skf_pkg::DELTA_BITS-1:0] SUM_MAX =
        skf_pkg::DELTA_BITS'(64'sh7fffffff);
    localparam logic signed [skf_pkg::DELTA_BITS-1:0] SUM_MIN =
        skf_pkg::DELTA_BITS'(-64'sh80000000);
    localparam logic signed [skf_pkg::PROD_BITS-1:0] HALF =
        skf_pkg::PROD_BITS'(64'd1 << (skf_pkg::GAIN_BITS - 1));

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PRED     = 3'd1;
    localparam logic [2:0] ST_DIVSTART = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_MULE     = 3'd4;
    localparam logic [2:0] ST_MULC     = 3'd5;
    localparam logic [2:0] ST_COVR     = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    logic [2:0]                                state_reg, state_next;
    logic [skf_pkg::NOISE_BITS-1:0]            process_noise_reg;
    logic [skf_pkg::NOISE_BITS-1:0]            measurement_noise_reg;
    logic signed [skf_pkg::EST_BITS-1:0]       cur_est_reg;
    logic [skf_pkg::COV_BITS-1:0]              cov_reg;
    logic signed [SAMPLE_BITS-1:0]             sample_reg;
    logic [skf_pkg::COV_BITS-1:0]              p_reg;
    logic signed [skf_pkg::ERR_BITS-1:0]       err_reg;
    logic [skf_pkg::GAIN_BITS:0]               gain_reg;
    logic                                      out_valid_reg;
    logic signed [skf_pkg::EST_BITS-1:0]       estimate_reg;
    logic [skf_pkg::GAIN_BITS:0]               gain_out_reg;

    logic signed [EXTW-1:0]                    samp_shift;
    logic signed [skf_pkg::EST_BITS-1:0]       meas;
    logic [skf_pkg::COV_BITS:0]                p_sum;
    logic [skf_pkg::COV_BITS-1:0]              p_sat;
    logic signed [skf_pkg::PROD_BITS-1:0]      prod;
    logic signed [skf_pkg::PROD_BITS-1:0]      prod_rnd;
    logic signed [skf_pkg::DELTA_BITS-1:0]     est_sum;
    logic signed [skf_pkg::EST_BITS-1:0]       est_new;
    logic [skf_pkg::DELTA_BITS-1:0]            cov_full;
    logic [skf_pkg::COV_BITS-1:0]              cov_new;
    logic                                      out_load;

    skf_pkg::div_request_t div_req;
    skf_pkg::div_status_t  div_stat;
    skf_pkg::mul_request_t mul_req;

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    skf_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;
    assign gain      = gain_out_reg;

    // Sample scaled to fixed point, clamped to the estimate range.
    always_comb
    begin
        samp_shift = EXTW'(sample_reg) <<< FRACTION_BITS;
        if (samp_shift > MEAS_MAX)
            meas = MEAS_MAX[skf_pkg::EST_BITS-1:0];
        else if (samp_shift < MEAS_MIN)
            meas = MEAS_MIN[skf_pkg::EST_BITS-1:0];
        else
            meas = samp_shift[skf_pkg::EST_BITS-1:0];
    end

    assign p_sum = {1'b0, cov_reg} + {1'b0, process_noise_reg};
    assign p_sat = p_sum[skf_pkg::COV_BITS] ? '1 : p_sum[skf_pkg::COV_BITS-1:0];

    // Both products are rounded to nearest, ties up, as the gain fraction drops.
    assign prod_rnd = prod + HALF;

    always_comb
    begin
        est_sum = skf_pkg::DELTA_BITS'(cur_est_reg)
                + $signed(prod_rnd[skf_pkg::PROD_BITS-1:skf_pkg::GAIN_BITS]);
        if (est_sum > SUM_MAX)
            est_new = SUM_MAX[skf_pkg::EST_BITS-1:0];
        else if (est_sum < SUM_MIN)
            est_new = SUM_MIN[skf_pkg::EST_BITS-1:0];
        else
            est_new = est_sum[skf_pkg::EST_BITS-1:0];
        cov_full = prod_rnd[skf_pkg::PROD_BITS-1:skf_pkg::GAIN_BITS];
        if (cov_full[skf_pkg::DELTA_BITS-1:skf_pkg::COV_BITS] != '0)
            cov_new = '1;
        else
            cov_new = cov_full[skf_pkg::COV_BITS-1:0];
    end

    always_comb
    begin
        div_req.start = (state_reg == ST_DIVSTART);
        div_req.num   = p_reg;
        div_req.den   = {1'b0, p_reg} + {1'b0, measurement_noise_reg};
    end

    always_comb
    begin
        mul_req.enable = 1'b0;
        mul_req.a      = gain_reg;
        mul_req.b      = err_reg;
        if (state_reg == ST_MULE)
            mul_req.enable = 1'b1;
        else if (state_reg == ST_MULC)
        begin
            mul_req.enable = 1'b1;
            mul_req.a      = skf_pkg::GAIN_ONE - gain_reg;
            mul_req.b      = $signed({1'b0, p_reg});
        end
    end

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_PRED;
            ST_PRED:
                state_next = ST_DIVSTART;
            ST_DIVSTART:
                state_next = ST_DIV;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_MULE;
            ST_MULE:
                state_next = ST_MULC;
            ST_MULC:
                state_next = ST_COVR;
            ST_COVR:
                state_next = ST_FINISH;
            ST_FINISH:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            process_noise_reg     <= skf_pkg::PROCESS_NOISE_RESET;
            measurement_noise_reg <= skf_pkg::MEASUREMENT_NOISE_RESET;
            cur_est_reg           <= '0;
            cov_reg               <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    skf_pkg::REG_PROCESS_NOISE:
                        process_noise_reg <= cfg_data;
                    skf_pkg::REG_MEASUREMENT_NOISE:
                        measurement_noise_reg <= cfg_data;
                    default:
                        ;
                endcase
            end
            if (state_reg == ST_MULC)
                cur_est_reg <= est_new;
            if (state_reg == ST_COVR)
                cov_reg <= cov_new;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            sample_reg <= sample;
        if (state_reg == ST_PRED)
        begin
            p_reg   <= p_sat;
            err_reg <= skf_pkg::ERR_BITS'(meas) - skf_pkg::ERR_BITS'(cur_est_reg);
        end
        if (state_reg == ST_DIV && div_stat.done)
            gain_reg <= div_stat.quotient;
        if (out_load)
        begin
            estimate_reg <= cur_est_reg;
            gain_out_reg <= gain_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_PRED)
        else $error("accepted sample did not start the prediction");

    a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULE) |-> gain_reg <= skf_pkg::GAIN_ONE)
        else $error("gain above one");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not presented");
`endif

endmodule

// File: design/skf_div.sv
module skf_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  skf_pkg::div_request_t req,
    output skf_pkg::div_status_t  stat
);

    localparam int REM_BITS = skf_pkg::COV_BITS + 2;

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [skf_pkg::DIV_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [REM_BITS-1:0]                 rem_reg, rem_next;
    logic [skf_pkg::GAIN_BITS:0]         quo_reg, quo_next;
    logic [skf_pkg::COV_BITS:0]          den_reg, den_next;
    logic [REM_BITS-1:0]                 rem_shift;
    logic                                take;

    assign rem_shift = rem_reg << 1;
    assign take      = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            den_next = req.den;
            if (req.den == '0)
            begin
                quo_next  = '0;
                done_next = 1'b1;
            end
            else if ({1'b0, req.num} == req.den)
            begin
                // No measurement noise: the sample is taken as it is.
                quo_next  = skf_pkg::GAIN_ONE;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = REM_BITS'(req.num);
                quo_next  = '0;
                cnt_next  = skf_pkg::DIV_CNT_BITS'(skf_pkg::GAIN_BITS - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = take ? rem_shift - REM_BITS'(den_reg) : rem_shift;
            quo_next = {quo_reg[skf_pkg::GAIN_BITS-1:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// File: design/skf_mul.sv
module skf_mul (
    input  logic                                     clk,
    input  skf_pkg::mul_request_t                    req,
    output logic signed [skf_pkg::PROD_BITS-1:0]     prod
);

    logic signed [skf_pkg::PROD_BITS-1:0] prod_reg;
    logic signed [skf_pkg::GAIN_BITS+1:0] a_ext;

    assign a_ext = $signed({1'b0, req.a});

    always_ff @(posedge clk)
    begin
        if (req.enable)
            prod_reg <= a_ext * req.b;
    end

    assign prod = prod_reg;

endmodule
